// ----- sv/tun_pkg.sv -----
// Shared constants for the triangle unit normal block.
package tun_pkg;

    // Default vertex coordinate width (signed Q7.8)
    localparam int COORD_WIDTH      = 16;
    // Default fraction bits of the normal (signed Q1.14)
    localparam int NORMAL_FRAC_BITS = 14;
    // Width of one normal component on the output
    localparam int OUT_W            = 16;
    // Coordinates per triangle
    localparam int NUM_COORD        = 9;
    // Saturation limits of one output component
    localparam int OUT_POS_LIM      = 32767;
    localparam int OUT_NEG_LIM      = 32768;

endpackage

// ----- sv/triangle_unit_normal.sv -----
// Top level: unit face normal of one triangle per transaction.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z
//  m_      | out | m_tvalid/m_tready | m_tdata: normal_x normal_y normal_z, m_tuser: degenerate
//
// One transaction per cycle unless a stalled result holds the chain; data passes the front
// pipeline, square root cells, integer quotient register, divider cells and output register.
// Reset clears all stage valid bits; no clearing pass.
// A stalled result freezes the whole chain; s_tready drops only then.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS,
    parameter int IN_W             = ((tun_pkg::NUM_COORD * COORD_WIDTH + 7) / 8) * 8,
    parameter int OUT_DW           = 3 * tun_pkg::OUT_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // normal_x, normal_y, normal_z
    output logic              m_tuser    // degenerate
);

    localparam int CW   = COORD_WIDTH;
    localparam int F    = NORMAL_FRAC_BITS;
    localparam int MW   = 2 * CW + 2;
    localparam int SW   = 2 * MW + 2;
    localparam int RW   = SW / 2;
    localparam int QW   = F + 1;
    localparam int OW   = tun_pkg::OUT_W;
    localparam int SQ_SD = 4 + 3 * MW;
    localparam int QXW  = (QW > OW + 1) ? QW : OW + 1;

    logic en;
    logic m_tvalid_reg;
    logic [OUT_DW-1:0] m_tdata_reg;
    logic m_tuser_reg;

    // the chain moves unless a finished result is held
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // unpack coordinates
    logic [tun_pkg::NUM_COORD-1:0][CW-1:0] coord;
    always_comb begin
        for (int i = 0; i < tun_pkg::NUM_COORD; i++) coord[i] = s_tdata[i*CW +: CW];
    end

    logic                 f_valid;
    logic [SW-1:0]        f_s;
    logic [2:0]           f_sign;
    logic [2:0][MW-1:0]   f_mag;
    logic                 f_deg;

    tun_front #(.CW(CW), .MW(MW), .SW(SW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_coord  (coord),
        .out_valid (f_valid),
        .out_s     (f_s),
        .out_sign  (f_sign),
        .out_mag   (f_mag),
        .out_deg   (f_deg)
    );

    // square root chain
    logic             sq_v    [RW+1];
    logic [RW-1:0]    sq_root [RW+1];
    logic [RW+2:0]    sq_rem  [RW+1];
    logic [SW-1:0]    sq_s    [RW+1];
    logic [SQ_SD-1:0] sq_side [RW+1];

    assign sq_v[0]    = f_valid;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;
    assign sq_s[0]    = f_s;
    assign sq_side[0] = {f_deg, f_sign, f_mag};

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        tun_sqrt_cell #(.RW(RW), .SW(SW), .SDW(SQ_SD)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[g]),
            .in_root   (sq_root[g]),
            .in_rem    (sq_rem[g]),
            .in_s      (sq_s[g]),
            .in_side   (sq_side[g]),
            .out_valid (sq_v[g+1]),
            .out_root  (sq_root[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_s     (sq_s[g+1]),
            .out_side  (sq_side[g+1])
        );
    end

    // integer quotient bit: magnitude never exceeds the root
    logic [2:0][MW-1:0] rt_mag;
    assign rt_mag = sq_side[RW][3*MW-1:0];

    logic               pr_valid_reg;
    logic [RW-1:0]      pr_root_reg;
    logic [2:0][RW-1:0] pr_rem_reg;
    logic [2:0][QW-1:0] pr_q_reg;
    logic [3:0]         pr_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_valid_reg <= 1'b0;
        end else if (en) begin
            pr_valid_reg <= sq_v[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (RW'(rt_mag[i]) >= sq_root[RW]) begin
                    pr_rem_reg[i] <= RW'(rt_mag[i]) - sq_root[RW];
                    pr_q_reg[i]   <= QW'(1);
                end else begin
                    pr_rem_reg[i] <= RW'(rt_mag[i]);
                    pr_q_reg[i]   <= '0;
                end
            end
            pr_root_reg <= sq_root[RW];
            pr_side_reg <= sq_side[RW][SQ_SD-1:3*MW];
        end
    end

    // division chain, one fraction bit per cell
    logic               dv_v    [F+1];
    logic [RW-1:0]      dv_root [F+1];
    logic [2:0][RW-1:0] dv_rem  [F+1];
    logic [2:0][QW-1:0] dv_q    [F+1];
    logic [3:0]         dv_side [F+1];

    assign dv_v[0]    = pr_valid_reg;
    assign dv_root[0] = pr_root_reg;
    assign dv_rem[0]  = pr_rem_reg;
    assign dv_q[0]    = pr_q_reg;
    assign dv_side[0] = pr_side_reg;

    for (genvar g = 0; g < F; g++) begin : g_div
        tun_div_cell #(.RW(RW), .QW(QW), .SDW(4)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[g]),
            .in_root   (dv_root[g]),
            .in_rem    (dv_rem[g]),
            .in_q      (dv_q[g]),
            .in_side   (dv_side[g]),
            .out_valid (dv_v[g+1]),
            .out_root  (dv_root[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_q     (dv_q[g+1]),
            .out_side  (dv_side[g+1])
        );
    end

    // apply sign, saturate, force zero on a degenerate triangle
    logic [2:0][OW-1:0] comp;
    logic [QXW-1:0]     qx;
    logic [QXW-1:0]     lim;
    logic [QXW-1:0]     mv;
    always_comb begin
        comp = '0;
        qx   = '0;
        lim  = '0;
        mv   = '0;
        for (int i = 0; i < 3; i++) begin
            qx  = QXW'(dv_q[F][i]);
            lim = dv_side[F][i] ? QXW'(tun_pkg::OUT_NEG_LIM) : QXW'(tun_pkg::OUT_POS_LIM);
            mv  = (qx > lim) ? lim : qx;
            if (dv_side[F][3]) begin
                comp[i] = '0;
            end else if (dv_side[F][i]) begin
                comp[i] = -mv[OW-1:0];
            end else begin
                comp[i] = mv[OW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_v[F];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= comp;
            m_tuser_reg <= dv_side[F][3];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- sv/tun_front.sv -----
// Front pipeline: edges, cross product, magnitudes and squared length.
module tun_front #(
    parameter int CW = tun_pkg::COORD_WIDTH,
    parameter int MW = 2 * CW + 2,
    parameter int SW = 2 * MW + 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [tun_pkg::NUM_COORD-1:0][CW-1:0] in_coord,
    output logic                           out_valid,
    output logic [SW-1:0]                  out_s,
    output logic [2:0]                     out_sign,
    output logic [2:0][MW-1:0]             out_mag,
    output logic                           out_deg
);

    localparam int EW  = CW + 1;
    localparam int PW  = 2 * EW;
    localparam int NW  = PW + 1;
    localparam int K   = MW / 2;
    localparam int HW  = MW - K;
    localparam int SQW = 2 * MW;

    logic [6:0] v_reg;

    logic signed [EW-1:0] e0_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [PW-1:0] p_reg  [6];
    logic signed [NW-1:0] n_reg  [3];
    logic [2:0]           sign4_reg, sign5_reg, sign6_reg, sign7_reg;
    logic [MW-1:0]        mag4_reg [3];
    logic [MW-1:0]        mag5_reg [3];
    logic [MW-1:0]        mag6_reg [3];
    logic [MW-1:0]        mag7_reg [3];
    logic                 deg4_reg, deg5_reg, deg6_reg, deg7_reg;
    logic [2*HW-1:0]      hh_reg [3];
    logic [HW+K-1:0]      hl_reg [3];
    logic [2*K-1:0]       ll_reg [3];
    logic [SQW-1:0]       sq_reg [3];
    logic [SW-1:0]        s_reg;

    // stage valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                // edges E0 = B - A, E1 = C - B
                e0_reg[i] <= $signed({in_coord[3+i][CW-1], in_coord[3+i]})
                           - $signed({in_coord[i][CW-1], in_coord[i]});
                e1_reg[i] <= $signed({in_coord[6+i][CW-1], in_coord[6+i]})
                           - $signed({in_coord[3+i][CW-1], in_coord[3+i]});
            end
            // cross product partial products
            p_reg[0] <= e0_reg[1] * e1_reg[2];
            p_reg[1] <= e0_reg[2] * e1_reg[1];
            p_reg[2] <= e0_reg[2] * e1_reg[0];
            p_reg[3] <= e0_reg[0] * e1_reg[2];
            p_reg[4] <= e0_reg[0] * e1_reg[1];
            p_reg[5] <= e0_reg[1] * e1_reg[0];
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= $signed({p_reg[2*i][PW-1], p_reg[2*i]})
                          - $signed({p_reg[2*i+1][PW-1], p_reg[2*i+1]});
            end
            // sign and magnitude
            for (int i = 0; i < 3; i++) begin
                sign4_reg[i] <= n_reg[i][NW-1];
                mag4_reg[i]  <= n_reg[i][NW-1] ? MW'(-n_reg[i]) : MW'(n_reg[i]);
            end
            deg4_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
            // squares split in halves
            for (int i = 0; i < 3; i++) begin
                hh_reg[i] <= (2*HW)'(mag4_reg[i][MW-1:K]) * (2*HW)'(mag4_reg[i][MW-1:K]);
                hl_reg[i] <= (HW+K)'(mag4_reg[i][MW-1:K]) * (HW+K)'(mag4_reg[i][K-1:0]);
                ll_reg[i] <= (2*K)'(mag4_reg[i][K-1:0]) * (2*K)'(mag4_reg[i][K-1:0]);
                sq_reg[i] <= (SQW'(hh_reg[i]) << (2*K)) + (SQW'(hl_reg[i]) << (K+1))
                           + SQW'(ll_reg[i]);
            end
            s_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            // side data alongside
            sign5_reg <= sign4_reg;
            sign6_reg <= sign5_reg;
            sign7_reg <= sign6_reg;
            deg5_reg  <= deg4_reg;
            deg6_reg  <= deg5_reg;
            deg7_reg  <= deg6_reg;
            for (int i = 0; i < 3; i++) begin
                mag5_reg[i] <= mag4_reg[i];
                mag6_reg[i] <= mag5_reg[i];
                mag7_reg[i] <= mag6_reg[i];
            end
        end
    end

    assign out_valid = v_reg[6];
    assign out_s     = s_reg;
    assign out_sign  = sign7_reg;
    assign out_deg   = deg7_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) out_mag[i] = mag7_reg[i];
    end

endmodule

// ----- sv/tun_sqrt_cell.sv -----
// One root bit of the digit-by-digit integer square root.
module tun_sqrt_cell #(
    parameter int RW  = 35,
    parameter int SW  = 2 * RW,
    parameter int SDW = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [RW-1:0]  in_root,
    input  logic [RW+2:0]  in_rem,
    input  logic [SW-1:0]  in_s,
    input  logic [SDW-1:0] in_side,
    output logic           out_valid,
    output logic [RW-1:0]  out_root,
    output logic [RW+2:0]  out_rem,
    output logic [SW-1:0]  out_s,
    output logic [SDW-1:0] out_side
);

    localparam int REMW = RW + 3;

    logic [REMW-1:0] cur;
    logic [REMW-1:0] trial;
    logic            ge;
    logic            valid_reg;
    logic [RW-1:0]   root_reg;
    logic [REMW-1:0] rem_reg;
    logic [SW-1:0]   s_reg;
    logic [SDW-1:0]  side_reg;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        cur   = {in_rem[REMW-3:0], in_s[SW-1:SW-2]};
        trial = REMW'({in_root, 2'b01});
        ge    = (cur >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= {in_root[RW-2:0], ge};
            rem_reg  <= ge ? (cur - trial) : cur;
            s_reg    <= in_s << 2;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_s     = s_reg;
    assign out_side  = side_reg;

endmodule

// ----- sv/tun_div_cell.sv -----
// One quotient bit of restoring division, three lanes sharing the root.
module tun_div_cell #(
    parameter int RW  = 35,
    parameter int QW  = 15,
    parameter int SDW = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RW-1:0]       in_root,
    input  logic [2:0][RW-1:0]  in_rem,
    input  logic [2:0][QW-1:0]  in_q,
    input  logic [SDW-1:0]      in_side,
    output logic                out_valid,
    output logic [RW-1:0]       out_root,
    output logic [2:0][RW-1:0]  out_rem,
    output logic [2:0][QW-1:0]  out_q,
    output logic [SDW-1:0]      out_side
);

    logic [RW:0]          t    [3];
    logic [2:0]           ge;
    logic                 valid_reg;
    logic [RW-1:0]        root_reg;
    logic [2:0][RW-1:0]   rem_reg;
    logic [2:0][QW-1:0]   q_reg;
    logic [SDW-1:0]       side_reg;

    // remainder stays below the root, so doubling fits RW+1 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i]  = {in_rem[i], 1'b0};
            ge[i] = (t[i] >= {1'b0, in_root});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= ge[i] ? RW'(t[i] - {1'b0, in_root}) : RW'(t[i]);
                q_reg[i]   <= {in_q[i][QW-2:0], ge[i]};
            end
            root_reg <= in_root;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// ----- sv/tun_checker.sv -----
// Port-level checks for the triangle unit normal block, bound to the top level.
module tun_checker #(
    parameter int OUT_DW = 48
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata,
    input logic              m_tuser
);

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // input is taken unless the output is blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("s_tready does not follow output stall");

    // degenerate results carry a zero normal
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result with nonzero normal");

    // a proper triangle never gives a zero normal
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata != '0)
        else $error("zero normal without degenerate flag");

endmodule

bind triangle_unit_normal tun_checker #(.OUT_DW(OUT_DW)) u_tun_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- dv/tun_checker.sv -----
// Checker for the triangle unit normal block: predicts each normal and compares.
`timescale 1ns / 1ps

module tun_scoreboard (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [143:0]  s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [47:0]   m_tdata,
    input  logic          m_tuser,
    output int            fail_count,
    output int            pending
);

    typedef struct packed {
        logic                         degenerate;
        logic [tun_pkg::OUT_W-1:0]    nz;
        logic [tun_pkg::OUT_W-1:0]    ny;
        logic [tun_pkg::OUT_W-1:0]    nx;
    } normal_t;

    normal_t expected_normals[$];
    int      fails = 0;

    assign pending    = expected_normals.size();
    assign fail_count = fails;

    // Integer square root, rounded down
    function automatic longint unsigned isqrt(logic [127:0] s);
        longint unsigned r;
        logic [127:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = {64'd0, r | (64'd1 << b)};
            if (c * c <= s)
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    // One component: truncated quotient, saturated to the output width
    function automatic logic [tun_pkg::OUT_W-1:0] scale_comp(longint c, longint unsigned root);
        logic [127:0] num;
        logic [127:0] q;
        longint unsigned m;
        m = (c < 0) ? -c : c;
        num = {64'd0, m} << tun_pkg::NORMAL_FRAC_BITS;
        q = num / {64'd0, root};
        if (c < 0)
            return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    function automatic normal_t face_normal(logic [143:0] d);
        longint v[9];
        longint e0x, e0y, e0z, e1x, e1y, e1z, cx, cy, cz;
        logic signed [127:0] wx, wy, wz;
        logic [127:0] s;
        longint unsigned root;
        normal_t r;
        for (int i = 0; i < tun_pkg::NUM_COORD; i++)
            v[i] = longint'($signed(d[16*i +: 16]));
        e0x = v[3] - v[0]; e0y = v[4] - v[1]; e0z = v[5] - v[2];
        e1x = v[6] - v[3]; e1y = v[7] - v[4]; e1z = v[8] - v[5];
        cx = e0y * e1z - e0z * e1y;
        cy = e0z * e1x - e0x * e1z;
        cz = e0x * e1y - e0y * e1x;
        // squares exceed 64 bits, so square in 128
        wx = 128'(cx);
        wy = 128'(cy);
        wz = 128'(cz);
        s = 128'(wx * wx + wy * wy + wz * wz);
        r = '0;
        if (s == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        root = isqrt(s);
        r.nx = scale_comp(cx, root);
        r.ny = scale_comp(cy, root);
        r.nz = scale_comp(cz, root);
        return r;
    endfunction

    task automatic report(string line);
        $display("[%0t] %s", $realtime, line);
        fails++;
    endtask

    // Predict on each input transaction, compare on each output transaction
    always @(posedge aclk) begin
        normal_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_normals = {expected_normals, face_normal(s_tdata)};
            if (m_tvalid && m_tready) begin
                if (expected_normals.size() == 0) begin
                    report("unexpected result transaction");
                end else begin
                    e = expected_normals.pop_front();
                    if (m_tdata[15:0] !== e.nx)
                        report($sformatf("normal_x mismatch: expected %0d, got %0d",
                                         $signed(e.nx), $signed(m_tdata[15:0])));
                    if (m_tdata[31:16] !== e.ny)
                        report($sformatf("normal_y mismatch: expected %0d, got %0d",
                                         $signed(e.ny), $signed(m_tdata[31:16])));
                    if (m_tdata[47:32] !== e.nz)
                        report($sformatf("normal_z mismatch: expected %0d, got %0d",
                                         $signed(e.nz), $signed(m_tdata[47:32])));
                    if (m_tuser !== e.degenerate)
                        report($sformatf("degenerate mismatch: expected %0d, got %0d",
                                         e.degenerate, m_tuser));
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: stimulus and verdict for the triangle unit normal block.
`timescale 1ns / 1ps

module tb_top;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 33;
    int           recv_idle_pct = 52;

    always #1 aclk = ~aclk;

    triangle_unit_normal u_top (.*);

    tun_scoreboard u_chk (.*);

    // Receiver stall pattern
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Send one triangle, honoring the sender idle rate; valid stays up between
    // back-to-back transactions
    task automatic send_triangle(logic [143:0] tri_data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tri_data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] rand_triangle();
        logic [143:0] t;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < tun_pkg::NUM_COORD; i++)
            t[16*i +: 16] = rand_coord(mode < 7 ? 3 : (mode == 7 ? 2 : $urandom_range(3)));
        // occasional degenerate: repeated vertex or collinear
        if ($urandom_range(19) == 0)
            t[143:96] = t[95:48];
        else if ($urandom_range(19) == 0)
            t[143:96] = {t[95:80] + (t[95:80] - t[47:32]),
                         t[79:64] + (t[79:64] - t[31:16]),
                         t[63:48] + (t[63:48] - t[15:0])};
        return t;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    initial begin
        logic [143:0] t;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, degenerate cases, axis-aligned normals
        send_triangle('0);
        send_triangle({9{16'h7fff}});
        send_triangle({16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                       16'h8000, 16'h8000, 16'h8000});
        send_triangle({16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                       16'h7fff, 16'h7fff, 16'h7fff});
        send_triangle({16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0});
        send_triangle({16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0});
        send_triangle({16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100});
        send_triangle({16'h0, 16'h0, 16'h0001, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0});
        send_triangle({16'h0003, 16'h0002, 16'h0001, 16'h0002, 16'h0001, 16'h0,
                       16'h0001, 16'h0, 16'hffff});
        send_triangle({16'h8000, 16'h0, 16'h7fff, 16'h7fff, 16'h8000, 16'h0,
                       16'h0, 16'h7fff, 16'h8000});
        send_triangle({16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff});

        // Hold off until the pipeline is empty
        drain();

        // Random: three idle profiles
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1 ? 52 : 0);
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1 ? 33 : 0);
            for (int n = 0; n < 215; n++) begin
                t = rand_triangle();
                send_triangle(t);
            end
        end
        drain();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tun_pkg.sv
sv/tun_front.sv
sv/tun_sqrt_cell.sv
sv/tun_div_cell.sv
sv/triangle_unit_normal.sv
sv/tun_checker.sv
dv/tun_checker.sv
dv/tb_top.sv
